FILE: hw/rtl/stfl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite timeline frame lookup package
// Fixed field widths and the controller state type shared by the block.
// ----------------------------------------------------------------------------
package stfl_pkg;

  localparam int NUM_BITS   = 64;
  localparam int DUR_BITS   = 16;
  localparam int DIV_CNT_W  = 6;

  localparam int MAX_FRAMES = 64;
  localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W      = DUR_BITS + IDX_W;

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } stfl_state_t;

endpackage

FILE: hw/rtl/stfl_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one append or query item.
// ----------------------------------------------------------------------------
interface stfl_req_if;
  import stfl_pkg::*;

  logic                valid;
  logic                ready;
  logic                action;
  logic [DUR_BITS-1:0] duration;
  logic [NUM_BITS-1:0] position;

  modport source (output valid, output action, output duration,
                  output position, input ready);
  modport sink (input valid, input action, input duration,
                input position, output ready);
endinterface

FILE: hw/rtl/stfl_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface stfl_rsp_if;
  import stfl_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] frame_index;
  logic             frame_valid;
  logic             append_dropped;
  logic [CNT_W-1:0] frame_count;
  logic [SUM_W-1:0] total_duration;

  modport source (output valid, output frame_index, output frame_valid,
                  output append_dropped, output frame_count,
                  output total_duration, input ready);
  modport sink (input valid, input frame_index, input frame_valid,
                input append_dropped, input frame_count,
                input total_duration, output ready);
endinterface

FILE: hw/rtl/sprite_timeline_frame_lookup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite timeline frame lookup
// Stores appended frame durations in a synchronous memory and maps a 1-based
// frame number to the sprite frame that covers it, optionally looping.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields
// req       in   action, duration, position
// rsp       out  frame_index, frame_valid, append_dropped, frame_count,
//                total_duration
// cfg       in   cfg_we, cfg_wdata (loop_enable)
//
// In loop mode a query first forms the bit-serial remainder by the total
// duration before the scan.
// The scan reads one table entry per cycle from the single memory read port.
// Reset clears the count, the total and loop_enable; the table is not cleared.
// A result waits in the output register while rsp is stalled.
// ----------------------------------------------------------------------------
module sprite_timeline_frame_lookup_top (
  input  logic        clk,
  input  logic        rst,
  stfl_req_if.sink    req,
  stfl_rsp_if.source  rsp,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);
  import stfl_pkg::*;

  logic [DUR_BITS-1:0] table_mem [MAX_FRAMES];

  stfl_state_t          state;
  logic                 loop_enable;
  logic [CNT_W-1:0]     count;
  logic [SUM_W-1:0]     sum;
  logic [NUM_BITS-1:0]  num;
  logic [SUM_W-1:0]     rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [CNT_W-1:0]     ptr;
  logic [SUM_W-1:0]     acc;
  logic                 rd_valid;
  logic [IDX_W-1:0]     rd_idx;
  logic [DUR_BITS-1:0]  rd_data;
  logic [IDX_W-1:0]     res_index;
  logic                 res_valid;
  logic                 res_dropped;

  logic                 accept;
  logic                 full;
  logic                 rd_en;
  logic                 out_load;
  logic [SUM_W:0]       div_trial;
  logic [SUM_W-1:0]     rem_next;
  logic [SUM_W-1:0]     acc_next;
  logic                 hit;
  logic                 last;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign full      = (count == CNT_W'(MAX_FRAMES));
  assign rd_en     = (state == ST_SCAN) && (ptr < count);
  assign out_load  = (state == ST_DONE) && (!rsp.valid || rsp.ready);

  assign div_trial = {rem, num[NUM_BITS-1]};
  assign rem_next  = (div_trial >= {1'b0, sum}) ? SUM_W'(div_trial - {1'b0, sum})
                                                : div_trial[SUM_W-1:0];
  assign acc_next  = acc + SUM_W'(rd_data);
  assign hit       = num < NUM_BITS'(acc_next);
  assign last      = (CNT_W'(rd_idx) == count - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (accept && req.action == ACT_APPEND && !full) begin
      table_mem[count[IDX_W-1:0]] <= req.duration;
    end
    if (rd_en) begin
      rd_data <= table_mem[ptr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_enable <= 1'b0;
    end else if (cfg_we) begin
      loop_enable <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      sum      <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.action == ACT_APPEND) begin
              if (!full) begin
                count <= count + CNT_W'(1);
                sum   <= sum + SUM_W'(req.duration);
              end
              state <= ST_DONE;
            end else if (sum == '0) begin
              state <= ST_DONE;
            end else if (loop_enable) begin
              state <= ST_DIV;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_DIV: begin
          if (div_cnt == DIV_CNT_W'(NUM_BITS - 1)) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_valid && (hit || last)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      ptr <= ptr + CNT_W'(1);
    end
    rd_idx <= ptr[IDX_W-1:0];
    unique case (state)
      ST_IDLE: begin
        num         <= req.position - NUM_BITS'(1);
        rem         <= '0;
        div_cnt     <= '0;
        ptr         <= '0;
        acc         <= '0;
        res_index   <= '0;
        res_valid   <= 1'b0;
        res_dropped <= (req.action == ACT_APPEND) && full;
      end
      ST_DIV: begin
        div_cnt <= div_cnt + DIV_CNT_W'(1);
        if (div_cnt == DIV_CNT_W'(NUM_BITS - 1)) begin
          num <= NUM_BITS'(rem_next);
        end else begin
          num <= {num[NUM_BITS-2:0], 1'b0};
          rem <= rem_next;
        end
      end
      ST_SCAN: begin
        if (rd_valid) begin
          acc <= acc_next;
          if (hit || last) begin
            res_index <= rd_idx;
            res_valid <= 1'b1;
          end
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.frame_index    <= res_index;
      rsp.frame_valid    <= res_valid;
      rsp.append_dropped <= res_dropped;
      rsp.frame_count    <= count;
      rsp.total_duration <= sum;
    end
  end

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.frame_valid |-> CNT_W'(rsp.frame_index) < count)
    else $error("Selected frame lies beyond the stored count.");

  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.append_dropped |-> rsp.frame_count == CNT_W'(MAX_FRAMES))
    else $error("Append dropped while the table had room.");

  a_scan_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> sum != '0 && count != '0)
    else $error("Scan started on an empty timeline.");

  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.frame_valid |-> !rsp.append_dropped)
    else $error("Result marks both a selected frame and a dropped append.");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite timeline frame lookup testbench
// Appends frame durations and queries frame numbers through the request
// channel. A scoreboard keeps its own copy of the duration table, count, total
// and loop setting, predicts each result, and compares every returned item in
// order. A directed part covers the empty table, zero durations, the frame
// number zero, the past-the-end case and looping. Random phases follow, under
// both loop settings, with no idling, with sender gaps, with receiver stalls,
// and with both.
// ----------------------------------------------------------------------------
module testbench;
  import stfl_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [5:0]  index;
    logic        selected;
    logic        dropped;
    logic [6:0]  count;
    logic [21:0] total;
  } lookup_result_t;

  class frame_lookup_scoreboard;
    logic [DUR_BITS-1:0] durations [TABLE_DEPTH];
    logic [6:0]          stored;
    logic [21:0]         total;
    bit                  wrap_on;
    lookup_result_t      awaited [$];
    int                  errors;

    function new();
      stored  = '0;
      total   = '0;
      wrap_on = 1'b0;
      errors  = 0;
    endfunction

    function void set_loop(bit on);
      wrap_on = on;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function logic [63:0] prefix(int upto);
      logic [63:0] acc;
      acc = '0;
      for (int i = 0; i < upto; i++) begin
        acc += {48'd0, durations[i]};
      end
      return acc;
    endfunction

    function void note_request(logic act, logic [DUR_BITS-1:0] dur,
                               logic [NUM_BITS-1:0] num);
      lookup_result_t r;
      logic [63:0]    rel;
      logic [63:0]    acc;
      bit             found;
      r = '0;
      if (act == ACT_APPEND) begin
        if (stored >= 7'(TABLE_DEPTH)) begin
          r.dropped = 1'b1;
        end else begin
          durations[stored[5:0]] = dur;
          stored = stored + 7'd1;
          total  = total + {6'd0, dur};
        end
      end else if (total != '0) begin
        rel = num - 64'd1;
        if (wrap_on) begin
          rel = rel % {42'd0, total};
        end
        r.index = 6'(stored - 7'd1);
        acc     = '0;
        found   = 1'b0;
        for (int i = 0; i < int'(stored); i++) begin
          acc += {48'd0, durations[i]};
          if (!found && rel < acc) begin
            r.index = 6'(i);
            found   = 1'b1;
          end
        end
        r.selected = 1'b1;
      end
      r.count = stored;
      r.total = total;
      awaited.push_back(r);
    endfunction

    task report(string field, longint unsigned got, longint unsigned want);
      if (errors < 40) begin
        $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, field, got,
                 want);
      end
      errors++;
    endtask

    task check_result(logic [5:0] idx, logic sel, logic drop, logic [6:0] cnt,
                      logic [21:0] tot);
      lookup_result_t want;
      if (awaited.size() == 0) begin
        report("result item with none outstanding, frame_index", idx, 0);
        return;
      end
      want = awaited.pop_front();
      if (idx !== want.index) report("frame_index", idx, want.index);
      if (sel !== want.selected) report("frame_valid", sel, want.selected);
      if (drop !== want.dropped) report("append_dropped", drop, want.dropped);
      if (cnt !== want.count) report("frame_count", cnt, want.count);
      if (tot !== want.total) report("total_duration", tot, want.total);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  int   src_idle_pct;
  int   sink_stall_pct;
  int   cycle_count = 0;

  frame_lookup_scoreboard sb;

  stfl_req_if req_ch ();
  stfl_rsp_if rsp_ch ();

  sprite_timeline_frame_lookup_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        sb.note_request(req_ch.action, req_ch.duration, req_ch.position);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        sb.check_result(rsp_ch.frame_index, rsp_ch.frame_valid, rsp_ch.append_dropped,
                        rsp_ch.frame_count, rsp_ch.total_duration);
      end
    end
  end

  task automatic send_item(logic act, logic [DUR_BITS-1:0] dur,
                           logic [NUM_BITS-1:0] num);
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.action   <= act;
    req_ch.duration <= dur;
    req_ch.position <= num;
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
  endtask

  task automatic append(logic [DUR_BITS-1:0] dur);
    send_item(ACT_APPEND, dur, {$urandom, $urandom});
  endtask

  task automatic query(logic [NUM_BITS-1:0] num);
    send_item(ACT_QUERY, DUR_BITS'($urandom), num);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_loop(bit on);
    cfg_we    <= 1'b1;
    cfg_wdata <= on;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_loop(on);
  endtask

  function automatic logic [DUR_BITS-1:0] pick_duration();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 70) return DUR_BITS'($urandom_range(1, 16));
    if (r < 75) return '1;
    return DUR_BITS'($urandom);
  endfunction

  function automatic logic [NUM_BITS-1:0] pick_number();
    int          r;
    logic [63:0] sum;
    sum = {42'd0, sb.total};
    r   = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return {$urandom, $urandom};
    if (r < 24) return '1;
    if (r < 45 && sb.stored != '0) begin
      return sb.prefix($urandom_range(0, int'(sb.stored) - 1)) + 64'($urandom_range(0, 2));
    end
    if (r < 58) return sum + 64'($urandom_range(0, 2));
    if (r < 68) return sum * 64'($urandom_range(2, 1000)) + 64'($urandom_range(0, 2));
    return 64'($urandom_range(0, int'(sb.total) * 3 + 3));
  endfunction

  initial begin
    sb = new();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_wdata       <= 1'b0;
    req_ch.valid    <= 1'b0;
    req_ch.action   <= ACT_APPEND;
    req_ch.duration <= '0;
    req_ch.position <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_loop(1'b0);

    query(64'd0);
    query('1);
    append(16'd0);
    append(16'd0);
    query(64'd1);
    append(16'hFFFF);
    append(16'd1);
    query(64'd0);
    query(64'd1);
    query(64'd65535);
    query(64'd65536);
    query(64'd65537);
    drain();
    write_loop(1'b1);
    query(64'd0);
    query(64'd65537);
    query(64'd65536);
    query('1);
    append(16'd3);
    query(64'd65540);
    query(64'd65539);
    query(64'd1);

    for (int p = 0; p < 8; p++) begin
      drain();
      write_loop(p[0]);
      case (p / 2)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 74;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 74;
        end
        default: begin
          src_idle_pct   = 14;
          sink_stall_pct = 14;
        end
      endcase
      for (int n = 0; n < 60; n++) begin
        if ($urandom_range(99) < 22) begin
          append(pick_duration());
        end else begin
          query(pick_number());
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
